// ----- hdl/rpts_pkg.sv -----
// shared types, codes and constants of the ram pattern test sequencer
`timescale 1ns / 1ps

package rpts_pkg;

    localparam int unsigned ADDR_W         = 32;
    localparam int unsigned WORD_BYTES     = 4;
    localparam int unsigned CHUNK_BYTES_DEF = 256;

    // operation codes of an input item
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // memory access kinds
    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_WRITE = 2'd1;
    localparam logic [1:0] ACC_READ  = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_ADDRESS   = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] random_word;
        logic [ADDR_W-1:0] read_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        access_kind;
        logic [ADDR_W-1:0] access_address;
        logic [ADDR_W-1:0] write_word;
        logic              finished;
        logic              passed;
        logic [ADDR_W-1:0] fail_address;
        logic [ADDR_W-1:0] expected_word;
        logic [ADDR_W-1:0] actual_word;
    } t_out_item;

    // status of the start address rounding unit
    typedef struct packed {
        logic            busy;
        logic [ADDR_W:0] rounded;
    } t_round_stat;

endpackage

// ----- hdl/rpts_stream_if.sv -----
// valid/ready stream channel carrying one payload item per transfer
`timescale 1ns / 1ps

interface rpts_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/ram_pattern_test_sequencer_core.sv -----
// memory self-test sequencer: write/read/verify passes over address chunks
`timescale 1ns / 1ps

// an item passes from the input register to the result register, where its result is offered; the single-pass
//   step logic between them gives one item per cycle while the output is ready and the rounding unit is idle
// after a write of start_address, items are held while the rounding unit
//   multiplies by the chunk reciprocal, forms the remainder and adds the round-up
// reset (synchronous, active low) clears both pipeline valids, the test state and the
//   end address register; the rounded start resets to zero
module ram_pattern_test_sequencer_core #(
    parameter int unsigned CHUNK_BYTES = rpts_pkg::CHUNK_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rpts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rpts_pkg::ADDR_W-1:0]    i_cfg_data,
    rpts_stream_if.sink                    i_in,
    rpts_stream_if.source                  o_out
);
    import rpts_pkg::*;

    localparam int unsigned NWORDS = (CHUNK_BYTES + WORD_BYTES - 1) / WORD_BYTES;
    localparam int unsigned IDX_W  = $clog2(NWORDS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NWORDS - 1);

    // configuration and rounding
    logic [ADDR_W-1:0] r_end_address;
    t_round_stat       round_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_address <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_END_ADDRESS: begin
                    r_end_address <= i_cfg_data;
                end
                default: begin
                    r_end_address <= r_end_address;
                end
            endcase
        end
    end

    rpts_round #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_round (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (i_cfg_we && (i_cfg_index == CFG_START_ADDRESS)),
        .i_start_address (i_cfg_data),
        .o_stat          (round_stat)
    );

    // input register and result register
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      move;

    // an item moves into the result register when the result slot is free or draining and the rounding unit is idle
    assign move       = r_in_valid && (!r_out_valid || o_out.ready) && !round_stat.busy;
    assign i_in.ready = !r_in_valid || move;

    // test state
    logic [ADDR_W-1:0] r_chunk_base;
    logic [IDX_W-1:0]  r_word_index;
    logic [1:0]        r_pass_phase;   // 0 write 1, 1 read 1, 2 write 2, 3 read 2
    logic [ADDR_W-1:0] r_pattern;
    logic              r_running;
    logic              r_read_pending;
    logic [IDX_W-1:0]  r_pending_index;
    logic              r_draining;     // last read of the last chunk has gone out

    logic [ADDR_W-1:0] n_chunk_base;
    logic [IDX_W-1:0]  n_word_index;
    logic [1:0]        n_pass_phase;
    logic [ADDR_W-1:0] n_pattern;
    logic              n_running;
    logic              n_read_pending;
    logic [IDX_W-1:0]  n_pending_index;
    logic              n_draining;
    t_out_item         n_out;

    logic [ADDR_W-1:0] pend_off;
    logic [ADDR_W-1:0] pend_exp;
    logic [ADDR_W-1:0] word_off;
    logic [ADDR_W-1:0] word_addr;
    logic [ADDR_W:0]   next_base;
    logic              stop;

    // byte offsets in the chunk of the pending read and of the current word
    assign pend_off  = ADDR_W'({r_pending_index, 2'b00});
    assign pend_exp  = r_pattern ^ pend_off;
    assign word_off  = ADDR_W'({r_word_index, 2'b00});
    assign word_addr = r_chunk_base + word_off;
    assign next_base = {1'b0, r_chunk_base} + (ADDR_W + 1)'(CHUNK_BYTES);

    always_comb begin
        n_chunk_base    = r_chunk_base;
        n_word_index    = r_word_index;
        n_pass_phase    = r_pass_phase;
        n_pattern       = r_pattern;
        n_running       = r_running;
        n_read_pending  = r_read_pending;
        n_pending_index = r_pending_index;
        n_draining      = r_draining;
        n_out           = '0;
        stop            = 1'b0;

        if (r_in.operation == OP_START) begin
            // start or restart: no access, empty region passes at once
            n_word_index    = '0;
            n_pass_phase    = '0;
            n_pattern       = '0;
            n_pending_index = '0;
            n_read_pending  = 1'b0;
            n_draining      = 1'b0;
            if (round_stat.rounded[ADDR_W] || (round_stat.rounded[ADDR_W-1:0] >= r_end_address)) begin
                n_chunk_base   = '0;
                n_running      = 1'b0;
                n_out.finished = 1'b1;
                n_out.passed   = 1'b1;
            end else begin
                n_chunk_base = round_stat.rounded[ADDR_W-1:0];
                n_running    = 1'b1;
            end
        end else if (r_running) begin
            // compare the word returned for last step's read first
            if (r_read_pending) begin
                n_read_pending = 1'b0;
                if (r_in.read_data != pend_exp) begin
                    n_out.finished      = 1'b1;
                    n_out.fail_address  = r_chunk_base + pend_off;
                    n_out.expected_word = pend_exp;
                    n_out.actual_word   = r_in.read_data;
                    n_running           = 1'b0;
                    n_draining          = 1'b0;
                    stop                = 1'b1;
                end else if (r_draining) begin
                    n_out.finished = 1'b1;
                    n_out.passed   = 1'b1;
                    n_running      = 1'b0;
                    n_draining     = 1'b0;
                    stop           = 1'b1;
                end
            end

            if (!stop) begin
                if (!r_pass_phase[0]) begin
                    // write pass: the pattern is sampled on its first word
                    if (r_word_index == '0) begin
                        n_pattern = r_in.random_word;
                    end
                    n_out.access_kind    = ACC_WRITE;
                    n_out.access_address = word_addr;
                    n_out.write_word     = n_pattern ^ word_off;
                end else begin
                    n_out.access_kind    = ACC_READ;
                    n_out.access_address = word_addr;
                    n_read_pending       = 1'b1;
                    n_pending_index      = r_word_index;
                end

                if (r_word_index == LAST_IDX) begin
                    n_word_index = '0;
                    if (r_pass_phase != 2'd3) begin
                        n_pass_phase = r_pass_phase + 2'd1;
                    end else begin
                        n_pass_phase = '0;
                        // stop at the top of the address space or at the end bound
                        if (next_base[ADDR_W] || (next_base[ADDR_W-1:0] >= r_end_address)) begin
                            n_draining = 1'b1;
                        end else begin
                            n_chunk_base = next_base[ADDR_W-1:0];
                        end
                    end
                end else begin
                    n_word_index = r_word_index + 1'b1;
                end
            end
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.payload;
        end
        if (move) begin
            r_out <= n_out;
        end
    end

    // test state advances once per item moved to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_base    <= '0;
            r_word_index    <= '0;
            r_pass_phase    <= '0;
            r_pattern       <= '0;
            r_running       <= 1'b0;
            r_read_pending  <= 1'b0;
            r_pending_index <= '0;
            r_draining      <= 1'b0;
        end else if (move) begin
            r_chunk_base    <= n_chunk_base;
            r_word_index    <= n_word_index;
            r_pass_phase    <= n_pass_phase;
            r_pattern       <= n_pattern;
            r_running       <= n_running;
            r_read_pending  <= n_read_pending;
            r_pending_index <= n_pending_index;
            r_draining      <= n_draining;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

`ifndef NO_ASSERTIONS
    // no item is stepped while the rounded start is still being computed
    a_no_step_while_rounding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |-> !round_stat.busy)
        else $error("item stepped while rounding unit busy");

    // a read can only be outstanding in a running test
    a_pending_needs_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_read_pending |-> r_running)
        else $error("read pending while test not running");

    // draining always waits on the final read of the last chunk
    a_drain_has_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (r_read_pending && r_running))
        else $error("draining without a pending read");

    // a finished report leaves the sequencer idle
    a_finish_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && n_out.finished) |=> !r_running)
        else $error("test still running after finished report");

    // memory accesses are issued only by a running test
    a_access_when_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && (n_out.access_kind != ACC_NONE)) |-> r_running)
        else $error("access issued while idle");
`endif

endmodule

// ----- hdl/rpts_round.sv -----
// start address round-up to a chunk boundary by reciprocal multiplication in multiply, remainder and add steps
`timescale 1ns / 1ps

module rpts_round #(
    parameter int unsigned CHUNK_BYTES = rpts_pkg::CHUNK_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [rpts_pkg::ADDR_W-1:0] i_start_address,
    output rpts_pkg::t_round_stat       o_stat
);
    import rpts_pkg::*;

    localparam int unsigned REM_W  = $clog2(CHUNK_BYTES);
    localparam int unsigned PROD_W = 2 * ADDR_W + 1;
    // ceiling of 2^(ADDR_W+REM_W) / CHUNK_BYTES, gives the exact quotient of any address
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << (ADDR_W + REM_W)) + 64'(CHUNK_BYTES) - 64'd1) / 64'(CHUNK_BYTES);
    localparam logic [ADDR_W:0]   RECIP   = (ADDR_W + 1)'(RECIP_WIDE);
    localparam logic [ADDR_W-1:0] CHUNK_A = ADDR_W'(CHUNK_BYTES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_REM  = 2'd2;
    localparam logic [1:0] S_ADD  = 2'd3;

    logic [1:0]        r_state;
    logic [ADDR_W-1:0] r_start;
    logic [PROD_W-1:0] r_prod;
    logic [REM_W-1:0]  r_rem;
    logic [ADDR_W:0]   r_rounded;

    logic [PROD_W-1:0] n_prod;
    logic [ADDR_W-1:0] quot;
    logic [REM_W-1:0]  n_rem;
    logic [ADDR_W:0]   n_rounded;

    always_comb begin
        n_prod = PROD_W'(r_start) * PROD_W'(RECIP);
        quot   = ADDR_W'(r_prod >> (ADDR_W + REM_W));
        n_rem  = REM_W'(r_start - quot * CHUNK_A);
        if (r_rem == '0) begin
            n_rounded = {1'b0, r_start};
        end else begin
            n_rounded = {1'b0, r_start} + ((ADDR_W + 1)'(CHUNK_BYTES) - (ADDR_W + 1)'(r_rem));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rounded <= '0;
        end else if (i_load) begin
            r_state <= S_MUL;
        end else begin
            case (r_state)
                S_MUL: begin
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_rounded <= n_rounded;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath: quotient product, then remainder
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_start <= i_start_address;
        end else if (r_state == S_MUL) begin
            r_prod <= n_prod;
        end else if (r_state == S_REM) begin
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy    = (r_state != S_IDLE);
    assign o_stat.rounded = r_rounded;

endmodule
